### sv/tcf_pkg.sv
package tcf_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQB,
    ST_SQC,
    ST_SQADD,
    ST_SQRT,
    ST_CORD,
    ST_GMUL,
    ST_DSTART,
    ST_DIV,
    ST_GSUM,
    ST_BMUL1,
    ST_BMUL2,
    ST_BSUM,
    ST_FIN
  } tcf_state_t;

  // register indexes
  localparam logic REG_GYRO_WEIGHT = 1'b0;

  localparam logic [15:0] GYRO_WEIGHT_RST = 16'd32113;
  localparam logic [16:0] ONE_Q15         = 17'd32768;
  localparam logic signed [23:0] DEG90_Q16 = 24'sd5898240;
  localparam logic [20:0] US_PER_S        = 21'd1000000;
  localparam logic [47:0] HALF_US         = 48'd500000;

  // atan(2^-i) in q16.16 degrees, rounded
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/tcf_isqrt.sv
module tcf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] sq,
  output logic [30:0] root,
  output logic        done
);
  import tcf_pkg::*;

  logic [61:0] n_r;
  logic [33:0] rem_r, rem_nxt, rem_sh, trial;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;

  // one result bit per cycle, two radicand bits shifted in
  always_comb begin
    rem_sh = {rem_r[31:0], n_r[61:60]};
    trial  = {root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= {sq, 30'b0};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        n_r    <= {n_r[59:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = root_r[30:0];
  assign done = done_r;

endmodule

### sv/tcf_cordic.sv
module tcf_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [30:0]        x0,
  input  logic signed [15:0] a,
  output logic signed [23:0] z,
  output logic               done
);
  import tcf_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  logic signed [33:0] x_r, y_r, xs, ys;
  logic signed [23:0] z_r, at;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, done_r;

  // shifted operands and table angle for this step
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = signed'({2'b00, atan_q16(5'(cnt_r))});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r    <= signed'({3'b000, x0});
        y_r    <= 34'(a) <<< 15;
        z_r    <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (!y_r[33]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign z    = z_r;
  assign done = done_r;

endmodule

### sv/tcf_rdiv.sv
module tcf_rdiv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] p,
  output logic signed [28:0] q,
  output logic               done
);
  import tcf_pkg::*;

  // 2^56 / 15625 rounded up, exact for dividends below 2^42
  localparam logic [42:0] RECIP_15625 = 43'd4611686018428;

  logic [41:0] n_r;
  logic [57:0] acc_r, acc_nxt;
  logic [56:0] part;
  logic [1:0]  cnt_r;
  logic        neg_r, busy_r, done_r;
  logic [47:0] mag;

  // magnitude plus half a unit, so the floor rounds halves away from zero
  assign mag = (p[47] ? 48'(-p) : 48'(p)) + HALF_US;

  // divide by one million as n/64 times the reciprocal of 15625,
  // one 14-bit slice of n/64 per cycle, low slice first
  always_comb begin
    part    = n_r[13:0] * RECIP_15625;
    acc_nxt = {14'b0, acc_r[57:14]} + {1'b0, part};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= p[47];
        n_r    <= mag[47:6];
        acc_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        n_r   <= {14'b0, n_r[41:14]};
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // halves round away from zero
  assign q    = neg_r ? -signed'(acc_r[56:28]) : signed'(acc_r[56:28]);
  assign done = done_r;

endmodule

### sv/tilt_complementary_filter.sv
// roll/pitch complementary filter
// in_* is a stream of sensor beats: tdata carries gyro rates, three
// accelerometer axes and the time step. out_* carries one beat per input
// with the filtered roll and pitch angles in q16.16 degrees.
// cfg_* is an apb-style port holding gyro_weight at byte address 0.
// each beat is processed by a sequencer over shared units: a 35x18
// multiplier, a bit-serial square root, a cordic and a reciprocal
// multiply for the divide by one million. the tilt of both axes is
// computed first (square root and cordic are skipped for an axis when
// both other axes are zero), then the gyro term and blend of each; the
// sequencer returns to idle and can take the next beat in the cycle after
// the result is written.
// in_tready is high only while the sequencer is idle; one result may wait
// in the output register while the next beat is taken and processed, and
// the sequencer holds before writing a new result until that one is taken.
// reset clears both angles, sets gyro_weight to 0.98 and empties the output.
module tilt_complementary_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // roll_rate, pitch_rate, accel_x, accel_y, accel_z, step_us
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // roll_out, pitch_out
  output logic [63:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import tcf_pkg::*;

  tcf_state_t state_r, state_nxt;

  logic [15:0] w_r;
  logic [16:0] w_eff;
  logic signed [31:0] roll_rate_r, pitch_rate_r, roll_r, pitch_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [15:0] dt_r;
  logic axis_r;
  logic signed [23:0] acc_r [2];
  logic signed [52:0] prod_r, s1_r, prod, s;
  logic signed [34:0] ma;
  logic signed [17:0] mb;
  logic [31:0] tmp_r, sq;
  logic signed [33:0] g_r;
  logic signed [37:0] rnd;
  logic signed [31:0] sat;
  logic signed [15:0] op_a, op_b;
  logic signed [31:0] cur_angle, cur_rate;
  logic out_valid_r;
  logic [63:0] out_data_r;

  logic sqrt_start, sqrt_done, cord_start, cord_done, div_start, div_done;
  logic [30:0] root;
  logic signed [23:0] zc;
  logic signed [28:0] dq;
  logic accept, out_free;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_GYRO_WEIGHT) ? {16'b0, w_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= GYRO_WEIGHT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == REG_GYRO_WEIGHT) begin
      w_r <= cfg_pwdata[15:0];
    end
  end

  assign w_eff = ({1'b0, w_r} > ONE_Q15) ? ONE_Q15 : {1'b0, w_r};

  // axis 0 is roll (a = y, b = x), axis 1 is pitch (a = x, b = y)
  always_comb begin
    op_a      = axis_r ? ax_r : ay_r;
    op_b      = axis_r ? ay_r : ax_r;
    cur_angle = axis_r ? pitch_r : roll_r;
    cur_rate  = axis_r ? pitch_rate_r : roll_rate_r;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_SQB:   begin ma = 35'(op_b);      mb = 18'(op_b); end
      ST_SQC:   begin ma = 35'(az_r);      mb = 18'(az_r); end
      ST_GMUL:  begin ma = 35'(cur_rate);  mb = signed'({2'b00, dt_r}); end
      ST_BMUL1: begin ma = 35'(g_r);       mb = signed'({1'b0, w_eff}); end
      ST_BMUL2: begin
        ma = 35'(acc_r[axis_r]);
        mb = signed'({1'b0, ONE_Q15}) - signed'({1'b0, w_eff});
      end
      default:  begin ma = '0;             mb = '0; end
    endcase
  end

  assign prod = 53'(ma) * 53'(mb);
  assign sq   = tmp_r + prod_r[31:0];

  // blend rounding and saturation
  always_comb begin
    s   = s1_r + prod_r + 53'sd16384;
    rnd = s[52:15];
    if (rnd > 38'sd2147483647)       sat = 32'sh7fffffff;
    else if (rnd < -38'sd2147483648) sat = 32'sh80000000;
    else                             sat = 32'(rnd);
  end

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SQB;
      ST_SQB:    state_nxt = ST_SQC;
      ST_SQC:    state_nxt = ST_SQADD;
      ST_SQADD:  state_nxt = (sq == 32'd0) ? (axis_r ? ST_GMUL : ST_SQB) : ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_nxt = ST_CORD;
      ST_CORD:   if (cord_done) state_nxt = axis_r ? ST_GMUL : ST_SQB;
      ST_GMUL:   state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_GSUM;
      ST_GSUM:   state_nxt = ST_BMUL1;
      ST_BMUL1:  state_nxt = ST_BMUL2;
      ST_BMUL2:  state_nxt = ST_BSUM;
      ST_BSUM:   state_nxt = axis_r ? ST_FIN : ST_GMUL;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // unit starts and handshake outputs
  always_comb begin
    in_tready  = 1'b0;
    sqrt_start = 1'b0;
    cord_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready  = 1'b1;
      ST_SQADD:  sqrt_start = (sq != 32'd0);
      ST_SQRT:   cord_start = sqrt_done;
      ST_DSTART: div_start  = 1'b1;
      default:   ;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      roll_r      <= '0;
      pitch_r     <= '0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready && state_r != ST_FIN) out_valid_r <= 1'b0;
      prod_r <= prod;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            roll_rate_r  <= in_tdata[31:0];
            pitch_rate_r <= in_tdata[63:32];
            ax_r         <= in_tdata[79:64];
            ay_r         <= in_tdata[95:80];
            az_r         <= in_tdata[111:96];
            dt_r         <= in_tdata[127:112];
            axis_r       <= 1'b0;
          end
        end
        ST_SQC: tmp_r <= prod_r[31:0];
        ST_SQADD: begin
          if (sq == 32'd0) begin
            if (op_a > 16'sd0)      acc_r[axis_r] <= DEG90_Q16;
            else if (op_a < 16'sd0) acc_r[axis_r] <= -DEG90_Q16;
            else                    acc_r[axis_r] <= '0;
            axis_r <= ~axis_r;
          end
        end
        ST_CORD: begin
          if (cord_done) begin
            acc_r[axis_r] <= zc;
            axis_r        <= ~axis_r;
          end
        end
        ST_GSUM:  g_r  <= 34'(cur_angle) + 34'(dq);
        ST_BMUL2: s1_r <= prod_r;
        ST_BSUM: begin
          if (axis_r) pitch_r <= sat;
          else        roll_r  <= sat;
          axis_r <= ~axis_r;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {pitch_r, roll_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tcf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .sq    (sq),
    .root  (root),
    .done  (sqrt_done)
  );

  tcf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x0    (root),
    .a     (op_a),
    .z     (zc),
    .done  (cord_done)
  );

  tcf_rdiv u_rdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .p     (prod_r[47:0]),
    .q     (dq),
    .done  (div_done)
  );

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import tcf_pkg::*;

  typedef struct packed {
    logic signed [31:0] roll_rate;
    logic signed [31:0] pitch_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        step_us;
  } sample_t;

  // pitch in the upper half, roll in the lower half, as on out_tdata
  typedef struct packed {
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
  } angles_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  tilt_complementary_filter dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [15:0]        weight_q15;
  logic signed [31:0] roll_q16;
  logic signed [31:0] pitch_q16;
  sample_t            pending_samples[$];
  angles_t            expected_angles[$];
  bit                 failed = 1'b0;
  bit                 stim_done = 1'b0;
  bit                 hold_sender = 1'b0;

  localparam longint ATAN_TBL[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // accelerometer tilt, atan(a / sqrt(b^2 + c^2)) in q16.16 degrees
  function automatic longint accel_tilt(longint a, longint b, longint c);
    longint x, y, z, xs, ys;
    longint unsigned sq;
    z = 0;
    sq = b * b + c * c;
    if (sq == 0) return a > 0 ? 5898240 : (a < 0 ? -5898240 : 0);
    x = int_sqrt(sq << 30);
    y = a * 32768;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  // gyro integration, blend and saturation for one axis
  function automatic logic signed [31:0] blend_angle(logic signed [31:0] angle,
      longint rate, longint dt, longint acc);
    longint p, d, g, w, s, r;
    p = rate * dt;
    d = p >= 0 ? (p + 500000) / 1000000 : -((-p + 500000) / 1000000);
    g = longint'(angle) + d;
    w = weight_q15 > 32768 ? 32768 : weight_q15;
    s = w * g + (32768 - w) * acc + 16384;
    r = s >= 0 ? s / 32768 : -((-s + 32767) / 32768);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic angles_t filter_step(sample_t s);
    angles_t o;
    roll_q16 = blend_angle(roll_q16, s.roll_rate, s.step_us,
                           accel_tilt(s.accel_y, s.accel_x, s.accel_z));
    pitch_q16 = blend_angle(pitch_q16, s.pitch_rate, s.step_us,
                            accel_tilt(s.accel_x, s.accel_y, s.accel_z));
    o.roll = roll_q16;
    o.pitch = pitch_q16;
    return o;
  endfunction

  function automatic logic [127:0] pack_sample(sample_t s);
    return {s.step_us, s.accel_z, s.accel_y, s.accel_x, s.pitch_rate, s.roll_rate};
  endfunction

  // driver: one beat per queued sample with a random gap after each
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_angles.push_back(filter_step(pending_samples.pop_front()));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0 && !hold_sender) begin
          in_tvalid <= 1'b1;
          in_tdata <= pack_sample(pending_samples[0]);
          send_gap <= $urandom_range(0, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls, check each result beat
  int recv_gap = 0;
  always @(posedge clk) begin
    angles_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_angles.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          failed = 1'b1;
        end else begin
          want = expected_angles.pop_front();
          if (got.roll !== want.roll) begin
            $error("roll_out expected %0d actual %0d", want.roll, got.roll);
            failed = 1'b1;
          end
          if (got.pitch !== want.pitch) begin
            $error("pitch_out expected %0d actual %0d", want.pitch, got.pitch);
            failed = 1'b1;
          end
        end
        recv_gap = $urandom_range(0, 9);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_tvalid || expected_angles.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_weight(logic [15:0] w);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 3'(REG_GYRO_WEIGHT) << 2; cfg_pwdata <= {16'd0, w};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    weight_q15 = w;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  function automatic sample_t rand_sample(bit wide);
    sample_t s;
    s.roll_rate = $urandom;
    s.pitch_rate = $urandom;
    if (!wide && $urandom_range(0, 2) != 0) begin
      s.roll_rate = $signed(s.roll_rate) >>> 12;
      s.pitch_rate = $signed(s.pitch_rate) >>> 12;
    end
    s.accel_x = 16'($urandom);
    s.accel_y = 16'($urandom);
    s.accel_z = 16'($urandom);
    s.step_us = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000));
    if ($urandom_range(0, 15) == 0) begin
      s.accel_x = '0; s.accel_z = '0;
    end
    if ($urandom_range(0, 15) == 0) begin
      s.accel_y = '0; s.accel_z = '0;
    end
    return s;
  endfunction

  function automatic sample_t mk(int rr, int pr, int ax, int ay, int az, int dt);
    sample_t s;
    s.roll_rate = rr; s.pitch_rate = pr;
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az); s.step_us = 16'(dt);
    return s;
  endfunction

  initial begin
    logic [15:0] weights[5];
    weights = '{16'd0, 16'd32768, 16'd65535, 16'd16384, 16'd32113};
    weight_q15 = GYRO_WEIGHT_RST;
    roll_q16 = 0;
    pitch_q16 = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, zero denominators, zero time step
    pending_samples.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_samples.push_back(mk(65536, -65536, 100, 0, 0, 1000));
    pending_samples.push_back(mk(0, 0, -100, 0, 0, 1000));
    pending_samples.push_back(mk(0, 0, 0, 100, 0, 0));
    pending_samples.push_back(mk(0, 0, 0, -32768, 0, 0));
    pending_samples.push_back(mk(32'h7fffffff, 32'h7fffffff, 32767, 32767, 32767, 65535));
    pending_samples.push_back(mk(32'h80000000, 32'h80000000, -32768, -32768, -32768, 65535));
    pending_samples.push_back(mk(32'h7fffffff, 32'h80000000, 0, 0, 16384, 65535));
    pending_samples.push_back(mk(-1, 1, -1, -1, -1, 1));
    pending_samples.push_back(mk(123456, -654321, 0, 0, -16384, 500));
    pending_samples.push_back(mk(0, 0, 32767, -32768, 0, 0));
    pending_samples.push_back(mk(0, 0, 0, 0, 0, 65535));
    wait_idle();

    // directed extreme weights, then random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      repeat (300) @(posedge clk);
      write_weight(weights[ph]);
      for (int k = 0; k < 4; k++) pending_samples.push_back(rand_sample(1'b1));
      for (int k = 0; k < 156; k++) pending_samples.push_back(rand_sample(1'b0));
      if (ph == 2) begin
        // sender holds off until the pipeline drains
        while (pending_samples.size() > 80) @(posedge clk);
        hold_sender = 1'b1;
        while (in_tvalid || expected_angles.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_idle();
    end
    stim_done = 1'b1;
    repeat (400) @(posedge clk);
    if (!failed && expected_angles.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
